/* rtl/pldm_pkg.sv */
`default_nettype none
package pldm_pkg;

  localparam int unsigned POS_W      = 20;
  localparam int unsigned CELL_W     = 16;
  localparam int unsigned GRID_IN_W  = 6;
  localparam int unsigned PIX_W      = CELL_W + GRID_IN_W;
  localparam int unsigned DIFF_W     = PIX_W + 1;
  localparam int unsigned SQ_W       = 48;
  localparam int unsigned ROOT_W     = SQ_W / 2;
  localparam int unsigned INT_W      = 16;
  localparam int unsigned LVL_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [INT_W-1:0]  FULL_Q8     = 16'd65280;
  localparam logic [CELL_W-1:0] CELL_W_RST  = 16'd768;
  localparam logic [CELL_W-1:0] CELL_H_RST  = 16'd432;
  localparam logic [LVL_W-1:0]  BASE_RST    = 8'd10;

  localparam int unsigned MAX_SOURCES_DEF = 16;
  localparam int unsigned GRID_W_DEF      = 40;
  localparam int unsigned GRID_H_DEF      = 40;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_EVAL  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_W = 2'd0,
    CFG_CELL_H = 2'd1,
    CFG_BASE   = 2'd2,
    CFG_SPARE  = 2'd3
  } cfg_e;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic        [POS_W-1:0] reach;
  } light_t;

endpackage
`default_nettype wire

/* rtl/point_light_darkness_map_unit.sv */
`default_nettype none
// channel | direction | handshake              | word
// in      | input     | in_valid_i/in_ready_o   | req_type, grid_x/y, source_x/y/radius
// out     | output    | out_valid_o/out_ready_i | status, darkness, shaded_darkness
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index, cfg_data
// clear, add and unused request types: word goes from S_IDLE through S_DONE into the
// output register; the next word is taken once the unit is back in S_IDLE
// evaluate: each stored source with nonzero reach goes through S_MUL, S_SQ and S_ROOT,
// those in reach also through S_DIV and S_ACC; S_FSTART/S_FWAIT take the final root
// every source slot is visited once through one shared root unit and divider
// reset clears the source count; cfg writes are always taken
// a finished word waits in the output register while the next word is taken
module point_light_darkness_map_unit #(
  parameter int unsigned MAX_SOURCES = pldm_pkg::MAX_SOURCES_DEF,
  parameter int unsigned GRID_W      = pldm_pkg::GRID_W_DEF,
  parameter int unsigned GRID_H      = pldm_pkg::GRID_H_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [pldm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [pldm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [1:0]                       req_type_i,
  input  wire logic [pldm_pkg::GRID_IN_W-1:0]   grid_x_i,
  input  wire logic [pldm_pkg::GRID_IN_W-1:0]   grid_y_i,
  input  wire logic signed [pldm_pkg::POS_W-1:0] source_x_i,
  input  wire logic signed [pldm_pkg::POS_W-1:0] source_y_i,
  input  wire logic [pldm_pkg::POS_W-1:0]       source_radius_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  status_o,
  output logic [pldm_pkg::LVL_W-1:0]            darkness_o,
  output logic [pldm_pkg::LVL_W-1:0]            shaded_darkness_o
);
  import pldm_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SOURCES + 1);
  localparam int unsigned SUM_W = 2 * INT_W + CNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_MUL, S_SQ, S_ROOT, S_DIV, S_ACC, S_ROT,
    S_FSTART, S_FWAIT, S_DONE
  } state_e;

  state_e state_q;

  logic [CELL_W-1:0] cell_w_q, cell_h_q;
  logic [LVL_W-1:0]  base_q;
  logic [CNT_W-1:0]  cnt_q, k_q;
  logic [PIX_W-1:0]  px_q, py_q;
  logic [DIFF_W-2:0] dx_q, dy_q;
  logic [2*(DIFF_W-1)-1:0] dxx_q, dyy_q;
  logic [SUM_W-1:0]  sum_q;
  logic [INT_W-1:0]  lum_q;
  logic              res_status_q, out_valid_q, out_status_q;
  logic [LVL_W-1:0]  res_dark_q, res_shade_q, out_dark_q, out_shade_q;

  light_t ring [MAX_SOURCES];
  light_t head, new_src;
  logic   shift, add_ok;

  logic                 in_acc;
  logic [GRID_IN_W-1:0] gx_sat, gy_sat;
  logic signed [DIFF_W:0] diff_x, diff_y;

  logic              sq_start, sq_done, div_start, div_done;
  logic [SQ_W-1:0]   sq_op;
  logic [ROOT_W-1:0] root;
  logic [INT_W-1:0]  alpha, light, dark16;
  logic [LVL_W-1:0]  dark8;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign head        = ring[0];
  assign new_src     = '{x: source_x_i, y: source_y_i, reach: source_radius_i};
  assign add_ok      = in_acc && (req_e'(req_type_i) == REQ_ADD) &&
                       (cnt_q < CNT_W'(MAX_SOURCES));
  assign shift       = (state_q == S_ROT);

  for (genvar i = 0; i < MAX_SOURCES; i++) begin : g_cell
    pldm_cell u_cell (
      .clk_i    (clk_i),
      .wr_en_i  (add_ok && (cnt_q == CNT_W'(i))),
      .wr_data_i(new_src),
      .shift_i  (shift),
      .nb_i     (ring[(i + 1) % MAX_SOURCES]),
      .data_o   (ring[i])
    );
  end

  assign gx_sat = (32'(grid_x_i) > GRID_W) ? GRID_IN_W'(GRID_W) : grid_x_i;
  assign gy_sat = (32'(grid_y_i) > GRID_H) ? GRID_IN_W'(GRID_H) : grid_y_i;

  assign diff_x = (DIFF_W+1)'(head.x) - $signed({2'b00, px_q});
  assign diff_y = (DIFF_W+1)'(head.y) - $signed({2'b00, py_q});

  assign sq_start = (state_q == S_SQ) || (state_q == S_FSTART);
  assign sq_op    = (state_q == S_FSTART) ? SQ_W'(sum_q)
                                          : SQ_W'(dxx_q) + SQ_W'(dyy_q);
  assign div_start = (state_q == S_ROOT) && sq_done &&
                     (root < ROOT_W'(head.reach));

  pldm_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .op_i   (sq_op),
    .done_o (sq_done),
    .root_o (root)
  );

  pldm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .dist_i (root[POS_W-1:0]),
    .reach_i(head.reach),
    .done_o (div_done),
    .alpha_o(alpha)
  );

  assign light  = (root > ROOT_W'(FULL_Q8)) ? FULL_Q8 : root[INT_W-1:0];
  assign dark16 = FULL_Q8 - light;
  assign dark8  = dark16[INT_W-1:INT_W-LVL_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cell_w_q     <= CELL_W_RST;
      cell_h_q     <= CELL_H_RST;
      base_q       <= BASE_RST;
      cnt_q        <= '0;
      k_q          <= '0;
      px_q         <= '0;
      py_q         <= '0;
      dx_q         <= '0;
      dy_q         <= '0;
      dxx_q        <= '0;
      dyy_q        <= '0;
      sum_q        <= '0;
      lum_q        <= '0;
      res_status_q <= 1'b0;
      res_dark_q   <= '0;
      res_shade_q  <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= 1'b0;
      out_dark_q   <= '0;
      out_shade_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_e'(cfg_index_i))
          CFG_CELL_W: cell_w_q <= cfg_data_i;
          CFG_CELL_H: cell_h_q <= cfg_data_i;
          CFG_BASE:   base_q   <= cfg_data_i[LVL_W-1:0];
          CFG_SPARE:  ;
          default:    ;
        endcase
      end
      if ((state_q == S_DONE) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            res_status_q <= (req_e'(req_type_i) == REQ_ADD) && !add_ok;
            res_dark_q   <= '0;
            res_shade_q  <= '0;
            state_q      <= (req_e'(req_type_i) == REQ_EVAL) ? S_FETCH : S_DONE;
            unique case (req_e'(req_type_i))
              REQ_CLEAR: cnt_q <= '0;
              REQ_ADD: begin
                if (add_ok) begin
                  cnt_q <= cnt_q + CNT_W'(1);
                end
              end
              REQ_EVAL: begin
                px_q  <= PIX_W'(gx_sat) * PIX_W'(cell_w_q);
                py_q  <= PIX_W'(gy_sat) * PIX_W'(cell_h_q);
                k_q   <= '0;
                sum_q <= '0;
              end
              REQ_NONE: ;
              default: ;
            endcase
          end
        end
        S_FETCH: begin
          if ((k_q < cnt_q) && (head.reach != '0)) begin
            dx_q    <= diff_x[DIFF_W] ? (DIFF_W-1)'(-diff_x) : diff_x[DIFF_W-2:0];
            dy_q    <= diff_y[DIFF_W] ? (DIFF_W-1)'(-diff_y) : diff_y[DIFF_W-2:0];
            state_q <= S_MUL;
          end else begin
            state_q <= S_ROT;
          end
        end
        S_MUL: begin
          dxx_q   <= dx_q * dx_q;
          dyy_q   <= dy_q * dy_q;
          state_q <= S_SQ;
        end
        S_SQ: state_q <= S_ROOT;
        S_ROOT: begin
          if (sq_done) begin
            state_q <= div_start ? S_DIV : S_ROT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            lum_q   <= FULL_Q8 - alpha;
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          sum_q   <= sum_q + SUM_W'(lum_q * lum_q);
          state_q <= S_ROT;
        end
        S_ROT: begin
          k_q     <= k_q + CNT_W'(1);
          state_q <= (k_q == CNT_W'(MAX_SOURCES - 1)) ? S_FSTART : S_FETCH;
        end
        S_FSTART: state_q <= S_FWAIT;
        S_FWAIT: begin
          if (sq_done) begin
            res_dark_q  <= dark8;
            res_shade_q <= (dark8 >= base_q) ? dark8 - base_q : '0;
            state_q     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_status_q <= res_status_q;
            out_dark_q   <= res_dark_q;
            out_shade_q  <= res_shade_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign darkness_o        = out_dark_q;
  assign shaded_darkness_o = out_shade_q;
endmodule
`default_nettype wire

/* rtl/pldm_cell.sv */
`default_nettype none
module pldm_cell (
  input  wire logic            clk_i,
  input  wire logic            wr_en_i,
  input  wire pldm_pkg::light_t wr_data_i,
  input  wire logic            shift_i,
  input  wire pldm_pkg::light_t nb_i,
  output pldm_pkg::light_t     data_o
);
  import pldm_pkg::*;

  light_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (wr_en_i) begin
      data_d = wr_data_i;
    end else if (shift_i) begin
      data_d = nb_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
endmodule
`default_nettype wire

/* rtl/pldm_isqrt.sv */
`default_nettype none
module pldm_isqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [pldm_pkg::SQ_W-1:0]   op_i,
  output logic                             done_o,
  output logic [pldm_pkg::ROOT_W-1:0]      root_o
);
  import pldm_pkg::*;

  logic [SQ_W-1:0] rem_q, rem_d, res_q, res_d, bit_q, bit_d, trial;
  logic            done_q, done_d;

  assign trial = res_q + bit_q;

  always_comb begin
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = op_i;
      res_d = '0;
      bit_d = SQ_W'(1) << (SQ_W - 2);
    end else if (bit_q != '0) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d  = bit_q >> 2;
      done_d = (bit_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= '0;
      done_q <= 1'b0;
    end else begin
      bit_q  <= bit_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];
endmodule
`default_nettype wire

/* rtl/pldm_div.sv */
`default_nettype none
module pldm_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [pldm_pkg::POS_W-1:0]   dist_i,
  input  wire logic [pldm_pkg::POS_W-1:0]   reach_i,
  output logic                              done_o,
  output logic [pldm_pkg::INT_W-1:0]        alpha_o
);
  import pldm_pkg::*;

  localparam int unsigned NUM_W = POS_W + INT_W;
  localparam int unsigned STEP_W = $clog2(INT_W + 1);

  logic [NUM_W-1:0]  num;
  logic [POS_W-1:0]  rem_q, rem_d, den_q, den_d;
  logic [INT_W-1:0]  low_q, low_d, quo_q, quo_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [POS_W:0]    trial;
  logic              done_q, done_d;

  // dist * 65280 as (dist << 16) - (dist << 8)
  assign num   = {dist_i, INT_W'(0)} - (NUM_W'(dist_i) << 8);
  assign trial = {rem_q, low_q[INT_W-1]};

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    low_d  = low_q;
    quo_d  = quo_q;
    step_d = step_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num[NUM_W-1:INT_W];
      low_d  = num[INT_W-1:0];
      den_d  = reach_i;
      quo_d  = '0;
      step_d = STEP_W'(INT_W);
    end else if (step_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = POS_W'(trial - {1'b0, den_q});
        quo_d = {quo_q[INT_W-2:0], 1'b1};
      end else begin
        rem_d = trial[POS_W-1:0];
        quo_d = {quo_q[INT_W-2:0], 1'b0};
      end
      low_d  = low_q << 1;
      step_d = step_q - STEP_W'(1);
      done_d = (step_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    low_q <= low_d;
    quo_q <= quo_d;
  end

  assign done_o  = done_q;
  assign alpha_o = quo_q;
endmodule
`default_nettype wire

/* bench/tb_point_light_darkness_map_unit.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_point_light_darkness_map_unit;
  import pldm_pkg::*;

  localparam int unsigned NUM_LIGHTS = 16;
  localparam int unsigned GRID_LIM   = 40;
  localparam longint unsigned FULL   = 65280;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [1:0]        kind;
    logic [5:0]        gx;
    logic [5:0]        gy;
    logic [19:0]       sx;
    logic [19:0]       sy;
    logic [19:0]       sr;
  } req_t;

  typedef struct packed {
    logic       status;
    logic [7:0] dark;
    logic [7:0] shaded;
  } shade_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] req_type_i = '0;
  logic [5:0] grid_x_i = '0;
  logic [5:0] grid_y_i = '0;
  logic signed [19:0] source_x_i = '0;
  logic signed [19:0] source_y_i = '0;
  logic [19:0] source_radius_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic status_o;
  logic [7:0] darkness_o;
  logic [7:0] shaded_darkness_o;

  point_light_darkness_map_unit u_dut (.*);

  // predictor state
  logic [15:0] cell_w = CELL_W_RST;
  logic [15:0] cell_h = CELL_H_RST;
  logic [7:0]  base_lvl = BASE_RST;
  longint      lx [NUM_LIGHTS];
  longint      ly [NUM_LIGHTS];
  longint unsigned lr [NUM_LIGHTS];
  int unsigned n_lights = 0;

  req_t   pending_reqs[$];
  shade_t expected_shades[$];
  int     mismatches = 0;
  longint cycles = 0;
  bit     hold_off = 1'b0;
  bit     in_taken = 1'b0;
  int     queued = 0;
  int     checked = 0;

  initial forever #4 clk_i = ~clk_i;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic shade_t shade_point(req_t r);
    shade_t o;
    longint unsigned gx, gy, sum, d, a, l, dx, dy, lit, dk;
    longint px, py;
    o = '0;
    case (req_e'(r.kind))
      REQ_CLEAR: n_lights = 0;
      REQ_ADD: begin
        if (n_lights >= NUM_LIGHTS) begin
          o.status = 1'b1;
        end else begin
          lx[n_lights] = longint'(signed'(r.sx));
          ly[n_lights] = longint'(signed'(r.sy));
          lr[n_lights] = 64'(r.sr);
          n_lights++;
        end
      end
      REQ_EVAL: begin
        gx = (r.gx > GRID_LIM) ? 64'(GRID_LIM) : 64'(r.gx);
        gy = (r.gy > GRID_LIM) ? 64'(GRID_LIM) : 64'(r.gy);
        px = gx * cell_w;
        py = gy * cell_h;
        sum = 0;
        for (int i = 0; i < n_lights; i++) begin
          if (lr[i] != 0) begin
            dx = (lx[i] >= px) ? lx[i] - px : px - lx[i];
            dy = (ly[i] >= py) ? ly[i] - py : py - ly[i];
            d = int_sqrt(dx * dx + dy * dy);
            a = (d * FULL) / lr[i];
            if (a < FULL) begin
              l = FULL - a;
              sum += l * l;
            end
          end
        end
        lit = int_sqrt(sum);
        if (lit > FULL) lit = FULL;
        dk = (FULL - lit) >> 8;
        o.dark = dk[7:0];
        o.shaded = (dk >= base_lvl) ? 8'(dk - base_lvl) : 8'd0;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int unsigned pick;
    r.kind = REQ_EVAL;
    r.gx = $urandom_range(0, 63) > 50 ? 6'($urandom) : 6'($urandom_range(0, 40));
    r.gy = $urandom_range(0, 63) > 50 ? 6'($urandom) : 6'($urandom_range(0, 40));
    pick = $urandom_range(0, 99);
    if (pick < 4) r.kind = REQ_CLEAR;
    else if (pick < 6) r.kind = REQ_NONE;
    else if (pick < 45) r.kind = REQ_ADD;
    if ($urandom_range(0, 3) == 0) begin
      r.sx = 20'($urandom);
      r.sy = 20'($urandom);
      r.sr = 20'($urandom);
    end else begin
      r.sx = 20'($urandom_range(0, 40 * 768));
      r.sy = 20'($urandom_range(0, 40 * 432));
      r.sr = 20'($urandom_range(0, 8000));
    end
    return r;
  endfunction

  function automatic req_t mk(req_e k, int gx, int gy, int sx, int sy, int sr);
    req_t r;
    r.kind = k;
    r.gx = 6'(gx);
    r.gy = 6'(gy);
    r.sx = 20'(sx);
    r.sy = 20'(sy);
    r.sr = 20'(sr);
    return r;
  endfunction

  function automatic void queue_req(req_t r);
    pending_reqs = {pending_reqs, r};
    queued++;
  endfunction

  task automatic cfg_write(cfg_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CELL_W: cell_w = val;
      CFG_CELL_H: cell_h = val;
      CFG_BASE:   base_lvl = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    wait (checked >= queued);
    repeat (2000) @(posedge clk_i);
  endtask

  // driver
  always @(negedge clk_i) begin
    static int gap = 0;
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (gap > 0) begin
          gap--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_t r;
          r = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          req_type_i <= r.kind;
          grid_x_i <= r.gx;
          grid_y_i <= r.gy;
          source_x_i <= r.sx;
          source_y_i <= r.sy;
          source_radius_i <= r.sr;
          gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) begin
    static int wait_cnt = 0;
    static int hold_left = 0;
    static bit held = 1'b0;
    if (hold_off && !held) begin
      held = 1'b1;
      hold_left = 1500;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (wait_cnt > 0) begin
      wait_cnt--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (out_valid_o && out_ready_i && $urandom_range(0, 2) == 0)
        wait_cnt = $urandom_range(0, 14);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cycles++;
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (in_taken) begin
      req_t r;
      r = {req_type_i, grid_x_i, grid_y_i, source_x_i, source_y_i, source_radius_i};
      expected_shades = {expected_shades, shade_point(r)};
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      shade_t got;
      got = {status_o, darkness_o, shaded_darkness_o};
      checked++;
      if (expected_shades.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", got);
      end else begin
        shade_t want;
        want = expected_shades.pop_front();
        if (want !== got) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty list, extremes, full list, unused type, zero radius
    queue_req(mk(REQ_EVAL, 0, 0, 0, 0, 0));
    queue_req(mk(REQ_NONE, 63, 63, -1, -1, 20'hFFFFF));
    queue_req(mk(REQ_ADD, 0, 0, 0, 0, 0));
    queue_req(mk(REQ_ADD, 0, 0, 100, 100, 5000));
    queue_req(mk(REQ_ADD, 0, 0, -524288, 524287, 20'hFFFFF));
    queue_req(mk(REQ_EVAL, 0, 0, 0, 0, 0));
    queue_req(mk(REQ_EVAL, 63, 63, 0, 0, 0));
    queue_req(mk(REQ_EVAL, 40, 1, 0, 0, 0));
    for (int i = 0; i < 15; i++)
      queue_req(mk(REQ_ADD, 0, 0, i * 700, i * 300, 20'h7FFFF));
    queue_req(mk(REQ_EVAL, 5, 5, 0, 0, 0));
    queue_req(mk(REQ_CLEAR, 0, 0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin cfg_write(CFG_CELL_W, 16'd1); cfg_write(CFG_CELL_H, 16'd1);
                 cfg_write(CFG_BASE, 16'd0); end
        1: begin cfg_write(CFG_CELL_W, 16'hFFFF); cfg_write(CFG_CELL_H, 16'hFFFF);
                 cfg_write(CFG_BASE, 16'd255); end
        2: begin cfg_write(CFG_CELL_W, 16'd768); cfg_write(CFG_CELL_H, 16'd432);
                 cfg_write(CFG_BASE, 16'd10); end
        3: begin cfg_write(CFG_CELL_W, 16'd0); cfg_write(CFG_CELL_H, 16'd0);
                 cfg_write(CFG_BASE, 16'd128); end
        default: begin cfg_write(CFG_CELL_W, 16'($urandom_range(1, 2000)));
                 cfg_write(CFG_CELL_H, 16'($urandom_range(1, 2000)));
                 cfg_write(CFG_BASE, 16'(8'($urandom))); end
      endcase
      for (int k = 0; k < 100; k++) queue_req(rand_req());
      if (ph == 2) hold_off = 1'b1;
      drain();
    end

    if (mismatches == 0 && expected_shades.size() == 0 && checked == queued) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
